### rtl/isa_pkg.sv
package isa_pkg;

  // table geometry
  localparam int SLOT_COUNT = 96;
  localparam int PRIO_MAX   = 15;

  // the slot search runs in groups of eight, then over the groups
  localparam int GRP_SIZE   = 8;
  localparam int GRP_IDX_W  = 3;
  localparam int GRP_COUNT  = (SLOT_COUNT + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W      = (GRP_COUNT > 1) ? $clog2(GRP_COUNT) : 1;
  localparam int IDX_W      = GRP_W + GRP_IDX_W;
  localparam int VEC_W      = GRP_COUNT * GRP_SIZE;

  // field widths
  localparam int MODE_W     = 2;
  localparam int EVENT_W    = 9;
  localparam int PRIO_IN_W  = 8;
  localparam int PRIO_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 7;
  localparam int EXT_W      = (IDX_W > SLOT_OUT_W) ? IDX_W : SLOT_OUT_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_REGISTER   = 2'd0,
    MODE_UNREGISTER = 2'd1,
    MODE_SET_PRIO   = 2'd2,
    MODE_LOOKUP     = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_PRIO   = 3'd1,
    ST_HELD       = 3'd2,
    ST_FULL       = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_NO_HANDLER = 3'd5
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic cmp;
    logic enc;
    logic exec;
  } isa_cmd_t;

  // lowest set bit of an eight-bit group
  function automatic logic [GRP_IDX_W-1:0] first_one8(input logic [GRP_SIZE-1:0] v);
    logic [GRP_IDX_W-1:0] idx;
    idx = '0;
    for (int i = GRP_SIZE - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = GRP_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/isa_ctrl.sv
module isa_ctrl import isa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output isa_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_ENC  = 4'b0100,
    S_EXEC = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   exec_go;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // the result register must be free, or freed this cycle, before execution
  assign exec_go = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CMP;
        end
      end
      S_CMP:  state_d = S_ENC;
      S_ENC:  state_d = S_EXEC;
      S_EXEC: begin
        if (exec_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = (out_valid_q && !out_ready_i) || exec_go;
  end

  always_comb begin
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    cmd_o.cmp  = (state_q == S_CMP);
    cmd_o.enc  = (state_q == S_ENC);
    cmd_o.exec = exec_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/isa_dpath.sv
module isa_dpath import isa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  isa_cmd_t              cmd_i,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [EVENT_W-1:0]    event_number_i,
  input  logic [PRIO_IN_W-1:0]  prio_level_i,
  input  logic                  handler_present_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_OUT_W-1:0] slot_index_o,
  output logic                  slot_found_o
);

  // captured item
  mode_e                mode_q;
  logic [EVENT_W-1:0]   ev_q;
  logic [PRIO_IN_W-1:0] prio_q;
  logic                 hnd_q;

  // slot table
  logic [SLOT_COUNT-1:0] valid_q;
  logic [EVENT_W-1:0]    event_q [SLOT_COUNT];
  logic [PRIO_W-1:0]     prio_tab_q [SLOT_COUNT];

  // search vectors and group results
  logic [VEC_W-1:0]     match_vec_d, match_vec_q;
  logic [VEC_W-1:0]     free_vec_d, free_vec_q;
  logic [GRP_COUNT-1:0] m_hit_q, f_hit_q;
  logic [GRP_IDX_W-1:0] m_idx_q [GRP_COUNT];
  logic [GRP_IDX_W-1:0] f_idx_q [GRP_COUNT];

  // final selection
  logic             m_hit, f_hit;
  logic [IDX_W-1:0] m_slot, f_slot;

  // table update and result
  logic              wr_en, wr_valid, wr_prio_only;
  logic [IDX_W-1:0]  wr_slot;
  logic [EVENT_W-1:0] wr_event;
  logic [PRIO_W-1:0] wr_prio;
  status_e           status_d, status_q;
  logic [IDX_W-1:0]  slot_d;
  logic              found_d, found_q;
  logic [EXT_W-1:0]  slot_ext_q;
  logic              prio_ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_e'(mode_i);
      ev_q   <= event_number_i;
      prio_q <= prio_level_i;
      hnd_q  <= handler_present_i;
    end
  end

  // compare against every slot, padding bits neither match nor count as free
  always_comb begin
    match_vec_d = '0;
    free_vec_d  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match_vec_d[i] = valid_q[i] && (event_q[i] == ev_q);
      free_vec_d[i]  = !valid_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      match_vec_q <= match_vec_d;
      free_vec_q  <= free_vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enc) begin
      for (int g = 0; g < GRP_COUNT; g++) begin
        m_hit_q[g] <= |match_vec_q[g*GRP_SIZE +: GRP_SIZE];
        f_hit_q[g] <= |free_vec_q[g*GRP_SIZE +: GRP_SIZE];
        m_idx_q[g] <= first_one8(match_vec_q[g*GRP_SIZE +: GRP_SIZE]);
        f_idx_q[g] <= first_one8(free_vec_q[g*GRP_SIZE +: GRP_SIZE]);
      end
    end
  end

  // lowest group with a hit
  always_comb begin
    m_hit  = 1'b0;
    f_hit  = 1'b0;
    m_slot = '0;
    f_slot = '0;
    for (int g = GRP_COUNT - 1; g >= 0; g--) begin
      if (m_hit_q[g]) begin
        m_hit  = 1'b1;
        m_slot = {GRP_W'(g), m_idx_q[g]};
      end
      if (f_hit_q[g]) begin
        f_hit  = 1'b1;
        f_slot = {GRP_W'(g), f_idx_q[g]};
      end
    end
  end

  assign prio_ok = (prio_q <= PRIO_IN_W'(PRIO_MAX));

  always_comb begin
    wr_en        = 1'b0;
    wr_prio_only = 1'b0;
    wr_valid     = 1'b0;
    wr_slot      = m_slot;
    wr_event     = '0;
    wr_prio      = '0;
    status_d     = ST_OK;
    slot_d       = '0;
    found_d      = 1'b0;
    case (mode_q)
      MODE_REGISTER: begin
        if (!hnd_q) begin
          status_d = ST_NO_HANDLER;
        end else if (!prio_ok) begin
          status_d = ST_BAD_PRIO;
        end else if (m_hit) begin
          status_d = ST_HELD;
        end else if (!f_hit) begin
          status_d = ST_FULL;
        end else begin
          wr_en    = 1'b1;
          wr_valid = 1'b1;
          wr_slot  = f_slot;
          wr_event = ev_q;
          wr_prio  = prio_q[PRIO_W-1:0];
          slot_d   = f_slot;
          found_d  = 1'b1;
        end
      end
      MODE_UNREGISTER: begin
        if (!m_hit) begin
          status_d = ST_NOT_FOUND;
        end else begin
          // freed slot goes back to zero event and priority
          wr_en   = 1'b1;
          slot_d  = m_slot;
          found_d = 1'b1;
        end
      end
      MODE_SET_PRIO: begin
        if (!prio_ok) begin
          status_d = ST_BAD_PRIO;
        end else if (!m_hit) begin
          status_d = ST_NOT_FOUND;
        end else begin
          wr_prio_only = 1'b1;
          wr_prio      = prio_q[PRIO_W-1:0];
          slot_d       = m_slot;
          found_d      = 1'b1;
        end
      end
      MODE_LOOKUP: begin
        if (m_hit) begin
          slot_d  = m_slot;
          found_d = 1'b1;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.exec && wr_en) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (wr_slot == IDX_W'(i)) begin
          valid_q[i] <= wr_valid;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (wr_slot == IDX_W'(i)) begin
          if (wr_en) begin
            event_q[i]    <= wr_event;
            prio_tab_q[i] <= wr_prio;
          end else if (wr_prio_only) begin
            prio_tab_q[i] <= wr_prio;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q   <= status_d;
      slot_ext_q <= EXT_W'(slot_d);
      found_q    <= found_d;
    end
  end

  assign status_o     = status_q;
  assign slot_index_o = slot_ext_q[SLOT_OUT_W-1:0];
  assign slot_found_o = found_q;

endmodule

### rtl/interrupt_slot_allocator.sv
// interrupt slot allocator: a table of slots, each with a valid mark, an
// event number and a priority
// input channel (in_valid_i / in_ready_o) carries one item: mode, event
// number, requested priority and handler-present flag; modes are register,
// unregister, set priority and lookup
// output channel (out_valid_o / out_ready_i) returns one result per item:
// status, slot index and slot-found flag
// the item goes through three steps before its result is registered
// (compare every slot, encode within groups of eight, select over groups
// and update the table); one item is in work at a time, so the next item
// is taken only once the last one has left that three-step search
// the result sits in an output register: the block goes back to idle and
// takes the next item while a result waits; that item stalls in its last
// step until the waiting result is taken
// reset empties the table (every slot free) and drops any pending result
module interrupt_slot_allocator import isa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [EVENT_W-1:0]    event_number_i,
  input  logic [PRIO_IN_W-1:0]  prio_level_i,
  input  logic                  handler_present_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_OUT_W-1:0] slot_index_o,
  output logic                  slot_found_o
);

  isa_cmd_t cmd;

  // sequencing of compare, encode and execute
  isa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // slot table, search and result register
  isa_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .mode_i            (mode_i),
    .event_number_i    (event_number_i),
    .prio_level_i      (prio_level_i),
    .handler_present_i (handler_present_i),
    .status_o          (status_o),
    .slot_index_o      (slot_index_o),
    .slot_found_o      (slot_found_o)
  );

  // an accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after an accepted item");

  // a failed operation never names a slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> !slot_found_o)
    else $error("failing status reported with a slot");

  // no slot means slot index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !slot_found_o) |-> (slot_index_o == '0))
    else $error("slot index set without a slot");

  // the execute command only fires when the result register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

// testbench for the interrupt slot allocator
// a directed table runs first, then random items in four phases:
// fill, mixed, fill again, drain
// every result is checked against its typed result or a predictor holding its own copy of the table
module tb import isa_pkg::*; ();

  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_ITEMS  = 928;
  localparam int PHASE_LEN     = RANDOM_ITEMS / 4;
  localparam int TAIL_ITEMS    = 100;  // no idling on either side here
  localparam int PRESSURE_AT   = 300;  // results taken before the long hold-off
  localparam int PRESSURE_LEN  = 400;  // hold-off length in cycles
  localparam int STUCK_LIMIT   = 2000; // cycles with no item moving on either side
  localparam int DRAIN_CYCLES  = 10;   // extra wait for stray results after the last expected one

  // one row of the directed table; typed_exp marks rows whose result is written out
  typedef struct packed {
    mode_e                  mode;
    logic [EVENT_W-1:0]     event_no;
    logic [PRIO_IN_W-1:0]   prio;
    logic                   handler;
    logic                   typed_exp;
    status_e                status;
    logic [SLOT_OUT_W-1:0]  slot;
    logic                   found;
  } stim_row_t;

  typedef struct packed {
    status_e                status;
    logic [SLOT_OUT_W-1:0]  slot;
    logic                   found;
  } slot_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [MODE_W-1:0]     mode_i;
  logic [EVENT_W-1:0]    event_number_i;
  logic [PRIO_IN_W-1:0]  prio_level_i;
  logic                  handler_present_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [STATUS_W-1:0]   status_o;
  logic [SLOT_OUT_W-1:0] slot_index_o;
  logic                  slot_found_o;

  // predictor copy of the slot table
  logic                 slot_used [SLOT_COUNT];
  logic [EVENT_W-1:0]   slot_event[SLOT_COUNT];
  logic [PRIO_W-1:0]    slot_prio [SLOT_COUNT];

  slot_result_t expected_results[$];
  stim_row_t    directed_rows[DIRECTED_ROWS];

  int  error_count     = 0;
  int  results_checked = 0;
  int  items_sent      = 0;
  int  stuck_cycles    = 0;
  int  status_count[8];
  bit  sender_calm     = 1'b0;  // sender offers back to back
  bit  quiet_tail      = 1'b0;  // neither side idles
  bit  pressure_done   = 1'b0;

  interrupt_slot_allocator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .event_number_i    (event_number_i),
    .prio_level_i      (prio_level_i),
    .handler_present_i (handler_present_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .slot_index_o      (slot_index_o),
    .slot_found_o      (slot_found_o)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // lowest valid slot holding the event, -1 when none
  function automatic int find_event(input logic [EVENT_W-1:0] ev);
    int hit;
    hit = -1;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_event[i] == ev) hit = i;
    end
    return hit;
  endfunction

  // works out the result of one item and updates the predictor table
  function automatic slot_result_t apply_to_table(input mode_e m,
                                                  input logic [EVENT_W-1:0] ev,
                                                  input logic [PRIO_IN_W-1:0] pr,
                                                  input logic hnd);
    slot_result_t r;
    int hit;
    int lowest_free;
    int taken;
    hit         = find_event(ev);
    lowest_free = -1;
    taken       = -1;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_used[i]) lowest_free = i;
    end
    r.status = ST_OK;
    r.slot   = '0;
    r.found  = 1'b0;
    case (m)
      MODE_REGISTER: begin
        // check order: handler, priority range, already held, room left
        if (!hnd) r.status = ST_NO_HANDLER;
        else if (pr > PRIO_MAX) r.status = ST_BAD_PRIO;
        else if (hit >= 0) r.status = ST_HELD;
        else if (lowest_free < 0) r.status = ST_FULL;
        else begin
          taken                  = lowest_free;
          slot_used[taken]       = 1'b1;
          slot_event[taken]      = ev;
          slot_prio[taken]       = pr[PRIO_W-1:0];
        end
      end
      MODE_UNREGISTER: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else begin
          // a freed slot goes back to all zero
          taken             = hit;
          slot_used[taken]  = 1'b0;
          slot_event[taken] = '0;
          slot_prio[taken]  = '0;
        end
      end
      MODE_SET_PRIO: begin
        // range check comes before the search
        if (pr > PRIO_MAX) r.status = ST_BAD_PRIO;
        else if (hit < 0) r.status = ST_NOT_FOUND;
        else begin
          taken            = hit;
          slot_prio[taken] = pr[PRIO_W-1:0];
        end
      end
      default: begin
        // lookup never fails, a miss is just not found = 0
        taken = hit;
      end
    endcase
    if (taken >= 0) begin
      r.slot  = SLOT_OUT_W'(taken);
      r.found = 1'b1;
    end
    return r;
  endfunction

  // event of a random occupied slot, or any event when the table is empty
  function automatic logic [EVENT_W-1:0] pick_held_event();
    int used_count;
    int k;
    used_count = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_used[i]) used_count++;
    end
    if (used_count == 0) return EVENT_W'($urandom_range(0, 511));
    k = $urandom_range(0, used_count - 1);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_used[i]) begin
        if (k == 0) return slot_event[i];
        k--;
      end
    end
    return '0;
  endfunction

  // offers one item, waits for it to be taken and records what should come back
  task automatic send_item(input mode_e m, input logic [EVENT_W-1:0] ev,
                           input logic [PRIO_IN_W-1:0] pr, input logic hnd,
                           input logic typed_exp, input slot_result_t typed_res);
    slot_result_t predicted;
    if (!sender_calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    mode_i            <= m;
    event_number_i    <= ev;
    prio_level_i      <= pr;
    handler_present_i <= hnd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = apply_to_table(m, ev, pr, hnd);
    if (typed_exp) expected_results.push_back(typed_res);
    else expected_results.push_back(predicted);
    status_count[predicted.status]++;
    items_sent++;
    @(negedge clk_i);
  endtask

  // sender: reset, directed table, then the random phases
  initial begin
    slot_result_t typed_res;
    mode_e m;
    logic [EVENT_W-1:0] ev;
    logic [PRIO_IN_W-1:0] pr;
    logic hnd;
    int phase;
    int roll;
    int reg_pct[4];
    int unreg_pct[4];
    int set_pct[4];

    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    mode_i            = MODE_LOOKUP;
    event_number_i    = '0;
    prio_level_i      = '0;
    handler_present_i = 1'b0;
    for (int i = 0; i < 8; i++) status_count[i] = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_used[i]  = 1'b0;
      slot_event[i] = '0;
      slot_prio[i]  = '0;
    end

    // mode mix per phase: fill, mixed, fill again, drain; the rest are lookups
    reg_pct   = '{80, 25, 80, 10};
    unreg_pct = '{ 5, 25,  5, 60};
    set_pct   = '{ 7, 25,  7, 15};

    // starts from an empty table; rows typed out carry their result inline
    directed_rows = '{
      // lookup on an empty table is ok but finds nothing
      '{MODE_LOOKUP,     9'd0,   8'd0,   1'b0, 1'b1, ST_OK,         7'd0, 1'b0},
      '{MODE_REGISTER,   9'd170, 8'd0,   1'b0, 1'b1, ST_NO_HANDLER, 7'd0, 1'b0},
      '{MODE_REGISTER,   9'd7,   8'd255, 1'b1, 1'b1, ST_BAD_PRIO,   7'd0, 1'b0},
      // first priority past the maximum
      '{MODE_REGISTER,   9'd7,   8'd16,  1'b1, 1'b1, ST_BAD_PRIO,   7'd0, 1'b0},
      '{MODE_REGISTER,   9'd511, 8'd15,  1'b1, 1'b1, ST_OK,         7'd0, 1'b1},
      '{MODE_REGISTER,   9'd511, 8'd3,   1'b1, 1'b1, ST_HELD,       7'd0, 1'b0},
      // priority is checked before the duplicate search
      '{MODE_REGISTER,   9'd511, 8'd200, 1'b1, 1'b1, ST_BAD_PRIO,   7'd0, 1'b0},
      // missing handler wins over everything
      '{MODE_REGISTER,   9'd511, 8'd200, 1'b0, 1'b1, ST_NO_HANDLER, 7'd0, 1'b0},
      '{MODE_REGISTER,   9'd0,   8'd0,   1'b1, 1'b1, ST_OK,         7'd1, 1'b1},
      '{MODE_UNREGISTER, 9'd300, 8'd0,   1'b1, 1'b1, ST_NOT_FOUND,  7'd0, 1'b0},
      '{MODE_SET_PRIO,   9'd300, 8'd9,   1'b1, 1'b1, ST_NOT_FOUND,  7'd0, 1'b0},
      '{MODE_SET_PRIO,   9'd511, 8'd255, 1'b1, 1'b1, ST_BAD_PRIO,   7'd0, 1'b0},
      // range check comes before the search, even for an unknown event
      '{MODE_SET_PRIO,   9'd300, 8'd16,  1'b1, 1'b1, ST_BAD_PRIO,   7'd0, 1'b0},
      '{MODE_SET_PRIO,   9'd511, 8'd0,   1'b0, 1'b0, ST_OK,         7'd0, 1'b0},
      '{MODE_LOOKUP,     9'd0,   8'd255, 1'b0, 1'b1, ST_OK,         7'd1, 1'b1},
      '{MODE_UNREGISTER, 9'd511, 8'd77,  1'b0, 1'b1, ST_OK,         7'd0, 1'b1},
      '{MODE_LOOKUP,     9'd511, 8'd0,   1'b1, 1'b1, ST_OK,         7'd0, 1'b0},
      // freed slot reads back event 0 but must not match it
      '{MODE_LOOKUP,     9'd0,   8'd0,   1'b1, 1'b1, ST_OK,         7'd1, 1'b1},
      // lowest free slot is reused
      '{MODE_REGISTER,   9'd256, 8'd10,  1'b1, 1'b0, ST_OK,         7'd0, 1'b0},
      '{MODE_UNREGISTER, 9'd511, 8'd0,   1'b1, 1'b0, ST_OK,         7'd0, 1'b0},
      '{MODE_SET_PRIO,   9'd0,   8'd15,  1'b0, 1'b0, ST_OK,         7'd0, 1'b0},
      '{MODE_LOOKUP,     9'd256, 8'd128, 1'b0, 1'b0, ST_OK,         7'd0, 1'b0}
    };

    // reset held, then released away from the rising edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      typed_res.status = directed_rows[i].status;
      typed_res.slot   = directed_rows[i].slot;
      typed_res.found  = directed_rows[i].found;
      send_item(directed_rows[i].mode, directed_rows[i].event_no, directed_rows[i].prio,
                directed_rows[i].handler, directed_rows[i].typed_exp, typed_res);
    end

    typed_res = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase       = n / PHASE_LEN;
      if (phase > 3) phase = 3;
      quiet_tail  = (n >= RANDOM_ITEMS - TAIL_ITEMS);
      // a stretch in the mixed phase where the sender never pauses
      sender_calm = quiet_tail || (n >= 300 && n < 360);

      roll = $urandom_range(0, 99);
      if (roll < reg_pct[phase]) m = MODE_REGISTER;
      else if (roll < reg_pct[phase] + unreg_pct[phase]) m = MODE_UNREGISTER;
      else if (roll < reg_pct[phase] + unreg_pct[phase] + set_pct[phase]) m = MODE_SET_PRIO;
      else m = MODE_LOOKUP;

      // registers mostly bring new events, the others mostly aim at held ones
      if ($urandom_range(0, 99) < ((m == MODE_REGISTER) ? 30 : 65)) ev = pick_held_event();
      else ev = EVENT_W'($urandom_range(0, 511));

      if ($urandom_range(0, 99) < 85) pr = PRIO_IN_W'($urandom_range(0, PRIO_MAX));
      else pr = PRIO_IN_W'($urandom_range(PRIO_MAX + 1, 255));

      hnd = ($urandom_range(0, 99) < 95);

      send_item(m, ev, pr, hnd, 1'b0, typed_res);
    end
    in_valid_i <= 1'b0;

    // let every expected result come back, then wait DRAIN_CYCLES longer for strays
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d items sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, error_count);
    $display("tb: ok %0d, bad priority %0d, held %0d, full %0d, not found %0d, no handler %0d",
             status_count[ST_OK], status_count[ST_BAD_PRIO], status_count[ST_HELD],
             status_count[ST_FULL], status_count[ST_NOT_FOUND], status_count[ST_NO_HANDLER]);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // receiver: random stall bursts, one long hold-off so the block backs up
  initial begin
    int hold;
    hold        = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!pressure_done && results_checked >= PRESSURE_AT) begin
        // sender keeps offering while this lasts
        pressure_done = 1'b1;
        hold          = PRESSURE_LEN;
        out_ready_i  <= 1'b0;
      end else if (hold > 0) begin
        hold--;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        hold         = $urandom_range(0, 15);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // result checker: each result against the oldest expectation
  always @(posedge clk_i) begin
    slot_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d slot %0d found %0d",
               status_o, slot_index_o, slot_found_o);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (status_o !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, status_o);
          error_count++;
        end
        if (slot_index_o !== exp_res.slot) begin
          $error("slot_index: expected %0d, got %0d", exp_res.slot, slot_index_o);
          error_count++;
        end
        if (slot_found_o !== exp_res.found) begin
          $error("slot_found: expected %0d, got %0d", exp_res.found, slot_found_o);
          error_count++;
        end
        results_checked++;
      end
    end
  end

  // watchdog: ends the run when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
